>>> design/c3zp_pkg.sv
// Shared constants and types of the 3x3 zero-padded convolution block.
// No dependencies; imported by conv3x3_zero_padded.
`timescale 1ns / 1ps

package c3zp_pkg;

   localparam int MAX_WIDTH  = 1024;                    // line buffer depth
   localparam int MIN_WIDTH  = 3;
   localparam int COL_W      = $clog2(MAX_WIDTH);       // column index / line address
   localparam int CNT_W      = $clog2(MAX_WIDTH + 1);   // holds MAX_WIDTH itself
   localparam int WIDTH_W    = 11;                      // image_width register
   localparam int CMP_W      = (CNT_W > WIDTH_W) ? CNT_W : WIDTH_W;
   localparam int PIX_W      = 8;
   localparam int PROD_W     = 2 * PIX_W;
   localparam int SUM_W      = PROD_W + 4;              // nine products
   localparam int CONV_W     = 19;
   localparam int KROW_W     = 3 * PIX_W;
   localparam int CSR_IDX_W  = 2;
   localparam int TAPS       = 9;
   localparam int TAIL_TAPS  = 6;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [KROW_W-1:0]  KERNEL_TOP_RESET    = KROW_W'(0);
   localparam logic [KROW_W-1:0]  KERNEL_MID_RESET    = KROW_W'(256);
   localparam logic [KROW_W-1:0]  KERNEL_BOTTOM_RESET = KROW_W'(0);
   localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET   = WIDTH_W'(1024);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KERNEL_TOP    = 2'd0,
      CSR_KERNEL_MID    = 2'd1,
      CSR_KERNEL_BOTTOM = 2'd2,
      CSR_IMAGE_WIDTH   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PHASE_FIRST = 3'b001,   // first row of a frame
      PHASE_BODY  = 3'b010,   // later image row
      PHASE_FLUSH = 3'b100    // flush row below the image
   } phase_type;

   typedef struct packed {
      logic signed [PIX_W-1:0] upper;
      logic signed [PIX_W-1:0] middle;
   } line_entry_type;

   // item between the accept stage and the window / multiply stage
   typedef struct packed {
      logic signed [PIX_W-1:0] pixel;
      phase_type               phase;
      logic [COL_W-1:0]        col;
      logic                    col_zero;
      logic                    last_col;
   } stage_b_type;

   typedef struct packed {
      logic signed [CONV_W-1:0] value;
      logic                     last_of_frame;
      logic                     last_of_run;
   } result_type;

endpackage

>>> design/conv3x3_zero_padded.sv
// Streaming 3x3 convolution with zero padding: line memory, window, multiply and
// sum stages and a result queue. Depends on c3zp_pkg.
// Order: a result is registered in stage B, the multiply stage and the result queue
//   before it is offered, the second result of a row end after the first. Rate: one
//   item per cycle unless the result queue is full; the item that closes a row holds
//   the multiply stage for its second result, and a first row gives no results.
// Reset clears pipeline control, queue, window and row position, sets the
//   identity kernel and width 1024. The line memory is not cleared.
`timescale 1ns / 1ps

module conv3x3_zero_padded
   import c3zp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_kind,
   input  logic signed [PIX_W-1:0]  req_pixel,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [CONV_W-1:0] rsp_conv_value,
   output logic                     rsp_last_of_frame,
   output logic                     rsp_last_of_run,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [KROW_W-1:0]        csr_wdata
);

   // ---------------- configuration ----------------
   logic [KROW_W-1:0]  kernel_ff [3];
   logic [WIDTH_W-1:0] width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff[0] <= KERNEL_TOP_RESET;
         kernel_ff[1] <= KERNEL_MID_RESET;
         kernel_ff[2] <= KERNEL_BOTTOM_RESET;
         width_ff     <= IMAGE_WIDTH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_KERNEL_TOP:    kernel_ff[0] <= csr_wdata;
            CSR_KERNEL_MID:    kernel_ff[1] <= csr_wdata;
            CSR_KERNEL_BOTTOM: kernel_ff[2] <= csr_wdata;
            CSR_IMAGE_WIDTH:   width_ff     <= csr_wdata[WIDTH_W-1:0];
            default:           ;
         endcase
      end
   end

   logic signed [PIX_W-1:0] coef [3][3];   // [row][col]
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            coef[r][c] = signed'(kernel_ff[r][PIX_W*c +: PIX_W]);
         end
      end
   end

   logic [CMP_W-1:0] width_ext;
   logic [CMP_W-1:0] width_eff;
   always_comb begin
      width_ext = CMP_W'(width_ff);
      if (width_ext < CMP_W'(MIN_WIDTH))      width_eff = CMP_W'(MIN_WIDTH);
      else if (width_ext > CMP_W'(MAX_WIDTH)) width_eff = CMP_W'(MAX_WIDTH);
      else                                    width_eff = width_ext;
   end

   // ---------------- pipeline control ----------------
   logic [COL_W-1:0] col_ff, col_in;
   phase_type        phase_ff, phase_in;
   logic             b_valid_ff, b_valid_in;
   stage_b_type      b_ff;
   logic             c_main_ff, c_tail_ff, c_lof_ff;
   logic             push, pop, c_free, b_go, accept, enter_b;

   logic [FIFO_CNT_W-1:0] fifo_cnt_ff;

   assign push      = (c_main_ff || c_tail_ff) && (fifo_cnt_ff < FIFO_CNT_W'(FIFO_DEPTH));
   assign c_free    = !(c_main_ff || c_tail_ff) || (push && !(c_main_ff && c_tail_ff));
   assign b_go      = b_valid_ff && c_free;
   assign req_stall = b_valid_ff && !c_free;
   assign accept    = req_valid && !req_stall;

   // ---------------- accept stage ----------------
   logic        col_zero, ignore, last_col;
   phase_type   phase_eff;
   stage_b_type b_in;

   always_comb begin
      col_zero  = (col_ff == '0);
      ignore    = col_zero && req_kind && (phase_ff == PHASE_FIRST);  // flush before any row
      phase_eff = (col_zero && req_kind && (phase_ff == PHASE_BODY)) ? PHASE_FLUSH : phase_ff;
      last_col  = CMP_W'(col_ff) >= (width_eff - CMP_W'(1));
      enter_b   = accept && !ignore;

      b_in.pixel    = (req_kind || (phase_eff == PHASE_FLUSH)) ? '0 : req_pixel;
      b_in.phase    = phase_eff;
      b_in.col      = col_ff;
      b_in.col_zero = col_zero;
      b_in.last_col = last_col;

      col_in   = col_ff;
      phase_in = phase_ff;
      if (enter_b) begin
         if (last_col) begin
            col_in   = '0;
            phase_in = (phase_eff == PHASE_FLUSH) ? PHASE_FIRST : PHASE_BODY;
         end else begin
            col_in   = col_ff + COL_W'(1);
            phase_in = phase_eff;
         end
      end

      b_valid_in = b_valid_ff;
      if (enter_b)   b_valid_in = 1'b1;
      else if (b_go) b_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         phase_ff   <= PHASE_FIRST;
         b_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         phase_ff   <= phase_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enter_b) b_ff <= b_in;
   end

   // ---------------- line memory ----------------
   // Read at accept, written back when the item leaves stage B. The same entry
   // comes back only a full row later, so reads and writes never overlap.
   line_entry_type line_mem [MAX_WIDTH];
   line_entry_type line_rd_ff;
   line_entry_type line_wr;

   always_ff @(posedge clock) begin
      if (enter_b) line_rd_ff <= line_mem[col_ff];
      if (b_go)    line_mem[b_ff.col] <= line_wr;
   end

   // ---------------- window and multiply stage ----------------
   logic signed [PIX_W-1:0]  win_ff [6];   // col j-2 rows 0..2, then col j-1
   logic signed [PIX_W-1:0]  cols [3][3];  // [col][row]
   logic signed [PIX_W-1:0]  b_mid;
   logic signed [PROD_W-1:0] prod_main_in [TAPS];
   logic signed [PROD_W-1:0] prod_tail_in [TAIL_TAPS];
   logic signed [PROD_W-1:0] prod_main_ff [TAPS];
   logic signed [PROD_W-1:0] prod_tail_ff [TAIL_TAPS];

   always_comb begin
      b_mid = (b_ff.phase == PHASE_FIRST) ? '0 : line_rd_ff.middle;
      for (int r = 0; r < 3; r++) begin
         cols[0][r] = b_ff.col_zero ? '0 : win_ff[r];
         cols[1][r] = b_ff.col_zero ? '0 : win_ff[3+r];
      end
      cols[2][0] = line_rd_ff.upper;
      cols[2][1] = b_mid;
      cols[2][2] = b_ff.pixel;

      line_wr.upper  = b_mid;
      line_wr.middle = b_ff.pixel;

      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_main_in[r*3+c] = coef[r][c] * cols[c][r];
         end
         for (int c = 0; c < 2; c++) begin
            prod_tail_in[r*2+c] = coef[r][c] * cols[c+1][r];  // right column padded
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else if (b_go) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r]   <= cols[1][r];
            win_ff[3+r] <= cols[2][r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_go) begin
         prod_main_ff <= prod_main_in;
         prod_tail_ff <= prod_tail_in;
         c_lof_ff     <= (b_ff.phase == PHASE_FLUSH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_main_ff <= 1'b0;
         c_tail_ff <= 1'b0;
      end else if (b_go) begin
         c_main_ff <= (b_ff.phase != PHASE_FIRST) && !b_ff.col_zero;
         c_tail_ff <= (b_ff.phase != PHASE_FIRST) && b_ff.last_col;
      end else if (push) begin
         if (c_main_ff) c_main_ff <= 1'b0;
         else           c_tail_ff <= 1'b0;
      end
   end

   // ---------------- sum stage ----------------
   result_type            push_data;
   logic signed [SUM_W-1:0] acc;
   logic signed [SUM_W-1:0] term;

   always_comb begin
      acc = '0;
      for (int i = 0; i < TAPS; i++) begin
         if (c_main_ff)          term = SUM_W'(prod_main_ff[i]);
         else if (i < TAIL_TAPS) term = SUM_W'(prod_tail_ff[i]);
         else                    term = '0;
         acc = acc + term;
      end
      push_data.value         = acc[CONV_W-1:0];
      push_data.last_of_frame = !c_main_ff && c_lof_ff;
      push_data.last_of_run   = !c_main_ff || !c_tail_ff;
   end

   // ---------------- result queue ----------------
   result_type            fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] fifo_cnt_in;

   assign rsp_valid = (fifo_cnt_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      fifo_cnt_in = fifo_cnt_ff;
      if (push && !pop)      fifo_cnt_in = fifo_cnt_ff + FIFO_CNT_W'(1);
      else if (pop && !push) fifo_cnt_in = fifo_cnt_ff - FIFO_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                    : wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                    : rd_ptr_ff + FIFO_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) fifo_ff[wr_ptr_ff] <= push_data;
   end

   assign rsp_conv_value    = fifo_ff[rd_ptr_ff].value;
   assign rsp_last_of_frame = fifo_ff[rd_ptr_ff].last_of_frame;
   assign rsp_last_of_run   = fifo_ff[rd_ptr_ff].last_of_run;

`ifndef SYNTHESIS
   // line read and write-back never touch the same entry in one cycle
   a_no_line_collision: assert property (@(posedge clock) disable iff (reset)
      (enter_b && b_go) |-> (col_ff != b_ff.col))
      else $error("line memory read/write collision");

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   // a row-end result is never followed directly by another row end
   a_tail_spacing: assert property (@(posedge clock) disable iff (reset)
      (push && c_tail_ff && !c_main_ff) |=> !c_tail_ff)
      else $error("back-to-back row-end results");
`endif

endmodule
